// ===== rtl/core/rps_pkg.sv =====
`default_nettype none

package rps_pkg;

  // Width of one random word and of the bound register.
  localparam int WORD_W  = 64;
  localparam int BOUND_W = 11;
  localparam int POS_W   = 10;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_SIZE_IN_USE = 1'b0;
  localparam logic [BOUND_W-1:0] SIZE_RESET = 11'd1024;

  localparam int DEFAULT_MAX_SIZE = 1024;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SINGLE,
    ST_SCRUB_RD,
    ST_SCRUB_WR,
    ST_DIV,
    ST_RD_A,
    ST_RD_B,
    ST_WR_A,
    ST_WR_B,
    ST_RD_Z,
    ST_EMIT1,
    ST_EMIT2
  } rps_state_t;

  // One command to the permutation store per cycle.
  typedef struct packed {
    logic rd;
    logic wr;
    logic scrub_rd;
    logic scrub_wr;
    logic new_epoch;
  } rps_mem_op_t;

endpackage

`default_nettype wire

// ===== rtl/core/rps_divider.sv =====
`default_nettype none

// Two radix-2 remainder lanes sharing one bit counter: lane A reduces the
// random word, lane B reduces 2^64 - d, both modulo d.
module rps_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rps_pkg::WORD_W-1:0]  dividend,
  input  wire logic [rps_pkg::BOUND_W-1:0] divisor,
  output logic                             busy,
  output logic [rps_pkg::BOUND_W-1:0]      rem_word,
  output logic [rps_pkg::BOUND_W-1:0]      rem_limit
);

  localparam int CNT_W = $clog2(rps_pkg::WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rps_pkg::WORD_W - 1);

  logic [rps_pkg::WORD_W-1:0]  dvd_a_r;
  logic [rps_pkg::WORD_W-1:0]  dvd_b_r;
  logic [rps_pkg::BOUND_W-1:0] rem_a_r;
  logic [rps_pkg::BOUND_W-1:0] rem_b_r;
  logic [rps_pkg::BOUND_W-1:0] div_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;

  // One restoring step: the remainder stays below the divisor.
  function automatic logic [rps_pkg::BOUND_W-1:0] mod_step(
    input logic [rps_pkg::BOUND_W-1:0] rem,
    input logic                        bit_in,
    input logic [rps_pkg::BOUND_W-1:0] d
  );
    logic [rps_pkg::BOUND_W:0] trial;
    trial = {rem, bit_in};
    if (trial >= {1'b0, d}) begin
      trial = trial - {1'b0, d};
    end
    return trial[rps_pkg::BOUND_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_a_r <= dividend;
      dvd_b_r <= '0 - rps_pkg::WORD_W'(divisor);
      rem_a_r <= '0;
      rem_b_r <= '0;
      div_r   <= divisor;
    end else if (busy_r) begin
      rem_a_r <= mod_step(rem_a_r, dvd_a_r[rps_pkg::WORD_W-1], div_r);
      rem_b_r <= mod_step(rem_b_r, dvd_b_r[rps_pkg::WORD_W-1], div_r);
      dvd_a_r <= {dvd_a_r[rps_pkg::WORD_W-2:0], 1'b0};
      dvd_b_r <= {dvd_b_r[rps_pkg::WORD_W-2:0], 1'b0};
    end
  end

  assign busy      = busy_r;
  assign rem_word  = rem_a_r;
  assign rem_limit = rem_b_r;

endmodule

`default_nettype wire

// ===== rtl/core/rps_store.sv =====
`default_nettype none

// Permutation store. Each entry carries a valid bit and the shuffle epoch in
// which it was written; an entry that is not valid for the current epoch reads
// as its own index. A scrub step per item clears entries from older epochs
// before the epoch counter can wrap back onto them.
module rps_store #(
  parameter int MAX_SIZE = rps_pkg::DEFAULT_MAX_SIZE,
  parameter int IDX_W    = $clog2(MAX_SIZE)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rps_pkg::rps_mem_op_t op,
  input  wire logic [IDX_W-1:0]     addr,
  input  wire logic [IDX_W-1:0]     wdata,
  output logic [IDX_W-1:0]          rd_value,
  output logic                      ready
);

  localparam int EPOCH_W = IDX_W + 1;
  localparam int MEM_W   = 1 + EPOCH_W + IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SIZE - 1);

  logic [MEM_W-1:0]   mem [MAX_SIZE];
  logic [MEM_W-1:0]   mem_rd_r;
  logic [IDX_W-1:0]   rd_addr_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [IDX_W-1:0]   clr_idx_r;
  logic               clearing_r;
  logic [IDX_W-1:0]   scrub_ptr_r;

  logic               stale;
  logic               we;
  logic               re;
  logic [IDX_W-1:0]   waddr;
  logic [IDX_W-1:0]   raddr;
  logic [MEM_W-1:0]   wword;

  assign stale = mem_rd_r[MEM_W-1] && (mem_rd_r[IDX_W +: EPOCH_W] != epoch_r);

  always_comb begin
    we    = clearing_r || op.wr || (op.scrub_wr && stale);
    re    = op.rd || op.scrub_rd;
    raddr = op.scrub_rd ? scrub_ptr_r : addr;
    waddr = addr;
    wword = {1'b1, epoch_r, wdata};
    if (clearing_r) begin
      waddr = clr_idx_r;
      wword = '0;
    end else if (op.scrub_wr) begin
      waddr = scrub_ptr_r;
      wword = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wword;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      mem_rd_r  <= mem[raddr];
      rd_addr_r <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_idx_r   <= '0;
      epoch_r     <= '0;
      scrub_ptr_r <= '0;
    end else begin
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_LAST) begin
          clearing_r <= 1'b0;
        end
      end
      if (op.new_epoch) begin
        epoch_r <= epoch_r + EPOCH_W'(1);
      end
      if (op.scrub_wr) begin
        scrub_ptr_r <= (scrub_ptr_r == IDX_LAST) ? '0 : scrub_ptr_r + IDX_W'(1);
      end
    end
  end

  assign rd_value = (mem_rd_r[MEM_W-1] && !stale) ? mem_rd_r[IDX_W-1:0] : rd_addr_r;
  assign ready    = !clearing_r;

endmodule

`default_nettype wire

// ===== rtl/core/random_permutation_shuffler.sv =====
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_random_word (64 bits)
// out_      output     out_valid/out_ready  out_position, out_entry_value, out_run_end,
//                                           out_perm_done
// APB       input      psel/penable/pready  paddr, pwdata, pwrite, prdata (size_in_use)
//
// An item with n of at least two passes a scrub read and write, the radix-2 remainder
// unit, and a swap through the store (two reads, two writes) before its result; the
// last step of a shuffle adds a read of entry zero and gives two results.
// An item with n of one loads its result from ST_SINGLE when the output slot is free.
// After reset the store is swept once, one entry per cycle, and no item is accepted
// until the sweep ends; register writes are taken as ever.
// The block takes one item at a time; a result waiting in the output register
// stalls only the step that would load the next result.
`default_nettype none

module random_permutation_shuffler #(
  parameter int MAX_SIZE = rps_pkg::DEFAULT_MAX_SIZE
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel: one random word per item.
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rps_pkg::WORD_W-1:0]     in_random_word,
  // Result channel.
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rps_pkg::POS_W-1:0]           out_position,
  output logic [rps_pkg::POS_W-1:0]           out_entry_value,
  output logic                                out_run_end,
  output logic                                out_perm_done,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rps_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rps_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int IDX_W   = $clog2(MAX_SIZE);
  localparam int BOUND_W = rps_pkg::BOUND_W;
  localparam int POS_W   = rps_pkg::POS_W;
  localparam logic [BOUND_W-1:0] BOUND_TWO = BOUND_W'(2);

  rps_pkg::rps_state_t state_r;
  rps_pkg::rps_state_t state_nxt;

  logic [BOUND_W-1:0]          size_r;
  logic [BOUND_W-1:0]          bound_r;
  logic [rps_pkg::WORD_W-1:0]  word_r;
  logic [IDX_W-1:0]            a_r;
  logic [IDX_W-1:0]            b_r;

  logic                        out_valid_r;
  logic [POS_W-1:0]            out_pos_r;
  logic [POS_W-1:0]            out_val_r;
  logic                        out_end_r;
  logic                        out_done_r;

  logic                        cfg_wr;
  logic                        accept;
  logic                        slot_free;
  logic [BOUND_W-1:0]          n_eff;
  logic [BOUND_W-1:0]          i_start;
  logic [BOUND_W-1:0]          i_m1;
  logic                        last_step;
  logic                        rejected;

  logic                        div_start;
  logic                        div_busy;
  logic [BOUND_W-1:0]          rem_word;
  logic [BOUND_W-1:0]          rem_limit;

  rps_pkg::rps_mem_op_t        mem_op;
  logic [IDX_W-1:0]            mem_addr;
  logic [IDX_W-1:0]            mem_wdata;
  logic [IDX_W-1:0]            rd_value;
  logic                        store_ready;

  logic                        res_load;
  logic [POS_W-1:0]            res_pos;
  logic [POS_W-1:0]            res_val;
  logic                        res_end;
  logic                        res_done;
  logic                        bound_step;

  // A write lands on the access cycle; the upper address bit picks the register,
  // so a write to the second word is dropped.
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[rps_pkg::CFG_ADDR_W-1:2] == rps_pkg::REG_SIZE_IN_USE);
  assign pready = 1'b1;
  assign prdata = (paddr[rps_pkg::CFG_ADDR_W-1:2] == rps_pkg::REG_SIZE_IN_USE) ?
                  rps_pkg::CFG_DATA_W'(size_r) : '0;

  // Size zero behaves as one element; sizes beyond the store saturate.
  always_comb begin
    n_eff = size_r;
    if (size_r == '0) begin
      n_eff = BOUND_W'(1);
    end else if (32'(size_r) > MAX_SIZE) begin
      n_eff = BOUND_W'(MAX_SIZE);
    end
  end

  // A bound of zero means the next item opens a new shuffle.
  assign i_start   = (bound_r == '0) ? n_eff : bound_r;
  assign accept    = in_valid && in_ready;
  assign i_m1      = bound_r - BOUND_W'(1);
  assign last_step = (bound_r == BOUND_TWO);
  assign rejected  = word_r < rps_pkg::WORD_W'(rem_limit);
  assign slot_free = !out_valid_r || out_ready;

  rps_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_random_word),
    .divisor   (i_start),
    .busy      (div_busy),
    .rem_word  (rem_word),
    .rem_limit (rem_limit)
  );

  rps_store #(
    .MAX_SIZE (MAX_SIZE),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (mem_op),
    .addr     (mem_addr),
    .wdata    (mem_wdata),
    .rd_value (rd_value),
    .ready    (store_ready)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rps_pkg::ST_CLEAR: begin
        if (store_ready) begin
          state_nxt = rps_pkg::ST_IDLE;
        end
      end
      rps_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (i_start < BOUND_TWO) ? rps_pkg::ST_SINGLE : rps_pkg::ST_SCRUB_RD;
        end
      end
      rps_pkg::ST_SINGLE: begin
        if (slot_free) begin
          state_nxt = rps_pkg::ST_IDLE;
        end
      end
      rps_pkg::ST_SCRUB_RD: state_nxt = rps_pkg::ST_SCRUB_WR;
      rps_pkg::ST_SCRUB_WR: state_nxt = rps_pkg::ST_DIV;
      rps_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_nxt = rejected ? rps_pkg::ST_IDLE : rps_pkg::ST_RD_A;
        end
      end
      rps_pkg::ST_RD_A: state_nxt = rps_pkg::ST_RD_B;
      rps_pkg::ST_RD_B: state_nxt = rps_pkg::ST_WR_A;
      rps_pkg::ST_WR_A: state_nxt = rps_pkg::ST_WR_B;
      rps_pkg::ST_WR_B: state_nxt = last_step ? rps_pkg::ST_RD_Z : rps_pkg::ST_EMIT1;
      rps_pkg::ST_RD_Z: state_nxt = rps_pkg::ST_EMIT1;
      rps_pkg::ST_EMIT1: begin
        if (slot_free) begin
          state_nxt = last_step ? rps_pkg::ST_EMIT2 : rps_pkg::ST_IDLE;
        end
      end
      rps_pkg::ST_EMIT2: begin
        if (slot_free) begin
          state_nxt = rps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rps_pkg::ST_CLEAR;
    endcase
  end

  // Outputs of each state: store commands, divider start and result loads.
  always_comb begin
    in_ready   = 1'b0;
    div_start  = 1'b0;
    mem_op     = '0;
    mem_addr   = IDX_W'(i_m1);
    mem_wdata  = b_r;
    res_load   = 1'b0;
    res_pos    = '0;
    res_val    = '0;
    res_end    = 1'b1;
    res_done   = 1'b1;
    bound_step = 1'b0;
    unique case (state_r)
      rps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && (i_start >= BOUND_TWO)) begin
          div_start        = 1'b1;
          mem_op.new_epoch = (bound_r == '0);
        end
      end
      rps_pkg::ST_SINGLE: begin
        res_load = slot_free;
      end
      rps_pkg::ST_SCRUB_RD: mem_op.scrub_rd = 1'b1;
      rps_pkg::ST_SCRUB_WR: mem_op.scrub_wr = 1'b1;
      rps_pkg::ST_RD_A: mem_op.rd = 1'b1;
      rps_pkg::ST_RD_B: begin
        mem_op.rd = 1'b1;
        mem_addr  = IDX_W'(rem_word);
      end
      rps_pkg::ST_WR_A: begin
        mem_op.wr = 1'b1;
        mem_wdata = rd_value;
      end
      rps_pkg::ST_WR_B: begin
        mem_op.wr = 1'b1;
        mem_addr  = IDX_W'(rem_word);
        mem_wdata = a_r;
      end
      rps_pkg::ST_RD_Z: begin
        mem_op.rd = 1'b1;
        mem_addr  = '0;
      end
      rps_pkg::ST_EMIT1: begin
        res_load   = slot_free;
        bound_step = slot_free;
        res_pos    = POS_W'(i_m1);
        res_val    = POS_W'(b_r);
        res_end    = !last_step;
        res_done   = 1'b0;
      end
      rps_pkg::ST_EMIT2: begin
        res_load = slot_free;
        res_val  = POS_W'(rd_value);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rps_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A register write abandons the shuffle in progress.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= rps_pkg::SIZE_RESET;
      bound_r <= '0;
    end else begin
      if (cfg_wr) begin
        size_r  <= pwdata[BOUND_W-1:0];
        bound_r <= '0;
      end else if (accept) begin
        bound_r <= (i_start < BOUND_TWO) ? '0 : i_start;
      end else if (bound_step) begin
        bound_r <= last_step ? '0 : i_m1;
      end
    end
  end

  // Word and the two swapped entries.
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_random_word;
    end
    if (state_r == rps_pkg::ST_RD_B) begin
      a_r <= rd_value;
    end
    if (state_r == rps_pkg::ST_WR_A) begin
      b_r <= rd_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_pos_r  <= res_pos;
      out_val_r  <= res_val;
      out_end_r  <= res_end;
      out_done_r <= res_done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_position    = out_pos_r;
  assign out_entry_value = out_val_r;
  assign out_run_end     = out_end_r;
  assign out_perm_done   = out_done_r;

endmodule

`default_nettype wire

// ===== rtl/core/rps_checker.sv =====
`default_nettype none

module rps_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [rps_pkg::POS_W-1:0]    out_position,
  input wire logic [rps_pkg::POS_W-1:0]    out_entry_value,
  input wire logic                         out_run_end,
  input wire logic                         out_perm_done
);

  // The completing result always closes its word and sits at entry zero.
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_perm_done |-> out_run_end && (out_position == '0))
    else $error("completing result malformed");

  // Only the last step of a shuffle gives two results; the first is entry one.
  a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_end |-> out_position == rps_pkg::POS_W'(1))
    else $error("unexpected first result of a pair");

  // The second result of a pair follows as soon as the first is taken.
  a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_end |=> out_valid && out_perm_done)
    else $error("second result of a pair missing");

  // Items are worked one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position) &&
    $stable(out_entry_value))
    else $error("stalled result changed");

endmodule

bind random_permutation_shuffler rps_checker u_rps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_position    (out_position),
  .out_entry_value (out_entry_value),
  .out_run_end     (out_run_end),
  .out_perm_done   (out_perm_done)
);

`default_nettype wire

// ===== dv/random_permutation_shuffler_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the Fisher-Yates permutation shuffler.
//
// An initial block programs the size register over the APB port and fills a
// queue of random words. A clocked driver hands those words to the block one
// item at a time, with random idle bursts. A clocked monitor mirrors every
// accepted word in a local shuffle predictor. That predictor has its own copy
// of the size register, the bound, the permutation store and its written-map.
// For each word it queues the entries that should become final. Each result
// the block returns is checked against the oldest queued entry, field by field.
module random_permutation_shuffler_tb;

  localparam int WORD_W       = rps_pkg::WORD_W;
  localparam int POS_W        = rps_pkg::POS_W;
  localparam int BOUND_W      = rps_pkg::BOUND_W;
  localparam int CFG_ADDR_W   = rps_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W   = rps_pkg::CFG_DATA_W;
  localparam int MAX_ENTRIES  = rps_pkg::DEFAULT_MAX_SIZE;
  localparam int ITEM_TARGET  = 1650;
  // The last stretch of the run goes with no idle cycles on either side.
  localparam int CALM_ITEMS   = 150;
  // A rejected word gives no result but keeps the block busy in the scrub and the
  // remainder steps, so before a register write we wait this long past the last result.
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 1000000;
  // Register index 1 does not exist, and writes to it must be ignored.
  localparam int REG_SPARE    = 1;
  localparam logic [CFG_ADDR_W-1:0] SIZE_ADDR  =
    CFG_ADDR_W'(int'(rps_pkg::REG_SIZE_IN_USE) * 4);
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(REG_SPARE * 4);
  localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0] WORD_ODD  = {(WORD_W / 2){2'b10}};
  localparam logic [WORD_W-1:0] WORD_EVEN = {(WORD_W / 2){2'b01}};

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] entry_value;
    logic             run_end;
    logic             perm_done;
  } final_entry_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [WORD_W-1:0]     in_random_word;
  logic                  out_valid;
  logic                  out_ready;
  logic [POS_W-1:0]      out_position;
  logic [POS_W-1:0]      out_entry_value;
  logic                  out_run_end;
  logic                  out_perm_done;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  random_permutation_shuffler dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_random_word  (in_random_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_position    (out_position),
    .out_entry_value (out_entry_value),
    .out_run_end     (out_run_end),
    .out_perm_done   (out_perm_done),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state: the register as last written, the live bound (zero means
  // the next word opens a new shuffle), and the store with its written-map.
  logic [BOUND_W-1:0] size_reg;
  int unsigned        bound_left;
  logic [POS_W-1:0]   perm_entries [MAX_ENTRIES];
  bit                 entry_written [MAX_ENTRIES];

  // Entries that the block still owes us, oldest first.
  final_entry_t       final_entries [$];
  logic [WORD_W-1:0]  words_to_send [$];

  bit  calm;
  bit  word_taken;
  int  send_gap;
  int  ready_hold;
  int  cycle_count;
  int  mismatches;
  int  words_queued;
  int  words_taken;
  int  rejected_words;
  int  perms_finished;
  int  results_checked;
  int  settings_written;

  // An entry that was never written since the shuffle began holds its own index.
  function automatic logic [POS_W-1:0] entry_at(input int unsigned idx);
    return entry_written[idx] ? perm_entries[idx] : POS_W'(idx);
  endfunction

  function automatic void put_entry(input int unsigned idx, input logic [POS_W-1:0] v);
    perm_entries[idx]  = v;
    entry_written[idx] = 1'b1;
  endfunction

  function automatic void note_final(input int unsigned pos, input logic [POS_W-1:0] v,
                                     input logic last_of_word, input logic completes);
    final_entries.push_back('{position: POS_W'(pos), entry_value: v,
                              run_end: last_of_word, perm_done: completes});
    if (completes) perms_finished++;
  endfunction

  // One Fisher-Yates step for one accepted random word.
  function automatic void shuffle_step(input logic [WORD_W-1:0] word);
    int unsigned       n;
    int unsigned       i;
    int unsigned       j;
    logic [POS_W-1:0]  top_val;
    logic [POS_W-1:0]  pick_val;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] reject_below;
    if (bound_left == 0) begin
      foreach (entry_written[k]) entry_written[k] = 1'b0;
      n = size_reg;
      if (n == 0) n = 1;
      if (n > MAX_ENTRIES) n = MAX_ENTRIES;
      bound_left = n;
    end
    // A one-element permutation is finished by every word, and nothing is rejected.
    if (bound_left < 2) begin
      bound_left = 0;
      note_final(0, entry_at(0), 1'b1, 1'b1);
      return;
    end
    i = bound_left;
    span = WORD_W'(i);
    // Words below 2^64 mod i would bias the pick, so they are dropped.
    // The shuffle still counts as started.
    reject_below = (WORD_W'(0) - span) % span;
    if (word < reject_below) begin
      rejected_words++;
      return;
    end
    j = int'(word % span);
    top_val  = entry_at(i - 1);
    pick_val = entry_at(j);
    put_entry(i - 1, pick_val);
    put_entry(j, top_val);
    if (i == 2) begin
      // The last swap fixes both remaining entries at once.
      note_final(1, entry_at(1), 1'b0, 1'b0);
      note_final(0, entry_at(0), 1'b1, 1'b1);
      bound_left = 0;
    end else begin
      note_final(i - 1, entry_at(i - 1), 1'b1, 1'b0);
      bound_left = i - 1;
    end
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // Sender side. A new word goes out once the previous one was taken at the
  // last rising edge, unless an idle burst is running.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || word_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() > 0) begin
          in_valid       <= 1'b1;
          in_random_word <= words_to_send.pop_front();
          if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
      // Receiver side: random stall bursts.
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        ready_hold = $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Both handshakes are seen at the rising edge. An accepted word is run
  // through the predictor, and an accepted result is checked against the
  // oldest pending entry.
  always @(posedge clk) begin
    final_entry_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding",
               $time, final_entries.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      word_taken = rst_n && in_valid && in_ready;
      if (word_taken) begin
        words_taken++;
        shuffle_step(in_random_word);
      end
      if (rst_n && out_valid && out_ready) begin
        if (final_entries.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing pending, expected none, got pos %0d value %0d",
                   $time, out_position, out_entry_value);
        end else begin
          want = final_entries.pop_front();
          results_checked++;
          check_field("position", want.position, out_position);
          check_field("entry_value", want.entry_value, out_entry_value);
          check_field("run_end", want.run_end, out_run_end);
          check_field("perm_done", want.perm_done, out_perm_done);
        end
      end
    end
  end

  // One APB transfer: a setup cycle, then an access cycle that completes when
  // pready is high at a rising edge.
  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data,
                            output logic [CFG_DATA_W-1:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (wr && addr == SIZE_ADDR) begin
      size_reg   = data[BOUND_W-1:0];
      bound_left = 0;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_size_reg();
    logic [CFG_DATA_W-1:0] rd;
    cfg_access(1'b0, SIZE_ADDR, '0, rd);
    if (rd !== CFG_DATA_W'(size_reg)) begin
      mismatches++;
      $display("%0t: size_in_use readback mismatch, expected %0d, got %0d",
               $time, size_reg, rd);
    end
  endtask

  // Wait until every queued word is in and every pending entry has come back.
  task automatic drain_results();
    while (words_to_send.size() != 0 || in_valid || final_entries.size() != 0)
      @(posedge clk);
  endtask

  // Bring the block to idle. A rejected last word gives no result, so the
  // extra wait covers one full item of latency.
  task automatic settle();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The upper bits of pwdata carry noise, since only the low bits belong to the register.
  task automatic set_size(input int unsigned value);
    logic [CFG_DATA_W-1:0] rd;
    logic [CFG_DATA_W-1:0] noise;
    settle();
    noise = $urandom;
    cfg_access(1'b1, SIZE_ADDR, {noise[CFG_DATA_W-1:BOUND_W], BOUND_W'(value)}, rd);
    settings_written++;
    check_size_reg();
  endtask

  task automatic send(input logic [WORD_W-1:0] word);
    words_to_send.push_back(word);
    words_queued++;
  endtask

  // Mostly full-range words. A few are small enough to fall under the
  // rejection threshold of a bound that is not a power of two.
  function automatic logic [WORD_W-1:0] make_word(input int unsigned span);
    if ($urandom_range(0, 9) == 0) return WORD_W'($urandom_range(0, 2 * span + 2));
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] rd;
    int unsigned size_val;
    int unsigned span;
    int unsigned count;
    int unsigned pick;
    bit          first_phase;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_random_word = '0;
    out_ready      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    size_reg       = rps_pkg::SIZE_RESET;
    bound_left     = 0;
    foreach (entry_written[k]) entry_written[k] = 1'b0;
    calm           = 1'b0;
    word_taken     = 1'b0;
    send_gap       = 0;
    ready_hold     = 0;
    cycle_count    = 0;
    mismatches     = 0;
    words_queued   = 0;
    words_taken    = 0;
    rejected_words = 0;
    perms_finished = 0;
    results_checked  = 0;
    settings_written = 0;
    first_phase    = 1'b1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The register must come out of reset at the full size.
    check_size_reg();

    // With the reset size of 1024 the first bound is a power of two, and the other words
    // are too large to be rejected. They hit the extremes of the word and alternating bits.
    send('0);
    send(WORD_ONES);
    send(WORD_ODD);
    send(WORD_EVEN);

    // For a size of three, 2^64 mod 3 is 1. So a zero first word is rejected
    // even though it opens the shuffle. The third word then finishes the shuffle
    // with two results, and the fourth opens a new one.
    set_size(3);
    send('0);
    send(64'd5);
    send(64'd7);
    send(64'd1);

    // A write to a register that does not exist must leave both the size and
    // the shuffle in progress alone. The next word finishes that shuffle.
    settle();
    cfg_access(1'b1, SPARE_ADDR, '1, rd);
    check_size_reg();
    send(WORD_ONES - 1);

    // One element, given directly or as size zero: every word finishes a shuffle.
    set_size(1);
    send('0);
    send(WORD_ONES);
    set_size(0);
    send(WORD_ODD);
    send(WORD_EVEN);

    // A size above the store depth saturates to 1024.
    set_size(2047);
    send({$urandom, $urandom});
    send(WORD_ONES);
    send('0);

    // Size two finishes on every word with the two-result step.
    set_size(2);
    send('0);
    send(WORD_ONES);

    // Size five rejects a zero first word. Rewriting the same size mid-shuffle
    // must abandon the shuffle and start over.
    set_size(5);
    send('0);
    send(64'd9);
    set_size(5);
    send(WORD_ONES);

    // Random phases. Mostly small sizes so that shuffles finish often, some
    // medium ones, and a few at one element or at the store depth and above.
    while (words_queued < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) size_val = $urandom_range(0, 1);
      else if (pick == 1) size_val = $urandom_range(MAX_ENTRIES, 2047);
      else if (pick < 5) size_val = $urandom_range(13, 100);
      else size_val = $urandom_range(2, 12);
      set_size(size_val);
      if (!calm && words_queued >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
      span = (size_val == 0) ? 1 : ((size_val > MAX_ENTRIES) ? MAX_ENTRIES : size_val);
      if (span >= MAX_ENTRIES) count = 30;
      else count = $urandom_range(span, 4 * span);
      if (count < 8) count = 8;
      if (count > 120) count = 120;
      for (int k = 0; k < count; k++) begin
        // Now and then the sender stops halfway until every result is back.
        if (k == count / 2 && (first_phase || $urandom_range(0, 3) == 0)) drain_results();
        send(make_word(span));
      end
      first_phase = 1'b0;
    end

    settle();
    $display("Run covered %0d words (%0d rejected) over %0d size settings, including 0, 1, 2",
             words_taken, rejected_words, settings_written);
    $display("and sizes past the store depth, with %0d results checked and %0d permutations done.",
             results_checked, perms_finished);
    if (mismatches == 0 && final_entries.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0t: %0d mismatches, %0d results never arrived", $time, mismatches,
               final_entries.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
